@@ rtl/six_axis_pd_thrust_law_unit_macros.svh @@
// Assertion macros shared by the thrust law RTL.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef SIX_AXIS_PD_THRUST_LAW_UNIT_MACROS_SVH
`define SIX_AXIS_PD_THRUST_LAW_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAPD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sapd same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SAPD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sapd next-cycle check failed");

`endif

@@ rtl/sapd_pkg.sv @@
package sapd_pkg;

  // Default widths of the data path.
  localparam int DATA_WIDTH_DEF = 24;
  localparam int GAIN_WIDTH_DEF = 16;

  // Fixed formats: Q12.12 data, 24-bit heave offset.
  localparam int FRAC_BITS    = 12;
  localparam int OFFSET_WIDTH = 24;
  localparam int AXES         = 3;

  // Sway-to-surge coupling factor 0.099 as 6488 / 2^16, applied to Q.24.
  localparam int SWAY_COUPLE   = 6488;
  localparam int COUPLE_WIDTH  = 13;
  localparam int COUPLE_SHIFT  = 4;

  // Yaw bands in Q12.12 degrees and their fixed torques in Q12.12.
  localparam int YAW_CMP_WIDTH = 20;
  localparam int YAW_BAND_HI   = 368640;
  localparam int YAW_BAND_MID  = 184320;
  localparam int YAW_BAND_LO   = 20480;
  localparam int YAW_TQ_HI     = 819;
  localparam int YAW_TQ_MID    = 410;
  localparam int YAW_TQ_LO     = 287;

  // Yaw band codes.
  localparam logic [1:0] BAND_NONE = 2'd0;
  localparam logic [1:0] BAND_LO   = 2'd1;
  localparam logic [1:0] BAND_MID  = 2'd2;
  localparam logic [1:0] BAND_HI   = 2'd3;

  // Configuration port: 64-bit registers at 8-byte spacing.
  localparam int APB_DATA_WIDTH = 64;
  localparam int APB_ADDR_WIDTH = 6;
  localparam int REG_SEL_LSB    = 3;
  localparam int REG_SEL_WIDTH  = APB_ADDR_WIDTH - REG_SEL_LSB;

  // Register indexes.
  localparam logic [REG_SEL_WIDTH-1:0] REG_POS_GAINS    = 3'd0;
  localparam logic [REG_SEL_WIDTH-1:0] REG_VEL_GAINS    = 3'd1;
  localparam logic [REG_SEL_WIDTH-1:0] REG_ATT_GAINS    = 3'd2;
  localparam logic [REG_SEL_WIDTH-1:0] REG_RATE_GAINS   = 3'd3;
  localparam logic [REG_SEL_WIDTH-1:0] REG_HEAVE_OFFSET = 3'd4;

endpackage

@@ rtl/six_axis_pd_thrust_law_unit.sv @@
// Flow: a taken request is held in the input register until the result register is empty or
// is being emptied, then moves into it; out_valid rises as the result register is loaded.
// Throughput: one request per cycle; the input register refills whenever it is empty or the result
// register is empty or is being emptied, and a stalled result holds the result and a full input register.
// Reset: rst clears both valid flags and all configuration registers to zero.
`include "six_axis_pd_thrust_law_unit_macros.svh"

module six_axis_pd_thrust_law_unit #(
  parameter int DATA_WIDTH = sapd_pkg::DATA_WIDTH_DEF,
  parameter int GAIN_WIDTH = sapd_pkg::GAIN_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sapd_pkg::APB_ADDR_WIDTH-1:0]  paddr,
  input  logic [sapd_pkg::APB_DATA_WIDTH-1:0]  pwdata,
  output logic [sapd_pkg::APB_DATA_WIDTH-1:0]  prdata,
  output logic                                 pready,
  // Input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [DATA_WIDTH-1:0]         pos_err_x,
  input  logic signed [DATA_WIDTH-1:0]         pos_err_y,
  input  logic signed [DATA_WIDTH-1:0]         pos_err_z,
  input  logic signed [DATA_WIDTH-1:0]         vel_err_x,
  input  logic signed [DATA_WIDTH-1:0]         vel_err_y,
  input  logic signed [DATA_WIDTH-1:0]         vel_err_z,
  input  logic signed [DATA_WIDTH-1:0]         att_err_roll,
  input  logic signed [DATA_WIDTH-1:0]         att_err_pitch,
  input  logic signed [DATA_WIDTH-1:0]         att_err_yaw,
  input  logic signed [DATA_WIDTH-1:0]         rate_roll,
  input  logic signed [DATA_WIDTH-1:0]         rate_pitch,
  input  logic signed [DATA_WIDTH-1:0]         rate_yaw,
  // Output channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [DATA_WIDTH-1:0]         force_surge,
  output logic signed [DATA_WIDTH-1:0]         force_sway,
  output logic signed [DATA_WIDTH-1:0]         force_heave,
  output logic signed [DATA_WIDTH-1:0]         torque_roll,
  output logic signed [DATA_WIDTH-1:0]         torque_pitch,
  output logic signed [DATA_WIDTH-1:0]         torque_yaw
);

  localparam int DW   = DATA_WIDTH;
  localparam int GW   = GAIN_WIDTH;
  localparam int PW   = DW + GW;
  localparam int CFW  = DW + sapd_pkg::COUPLE_WIDTH;
  localparam int CPW  = CFW - sapd_pkg::COUPLE_SHIFT;
  localparam int OFW  = sapd_pkg::OFFSET_WIDTH + sapd_pkg::FRAC_BITS;
  localparam int SW0  = (PW > CPW + 1) ? PW : CPW + 1;
  localparam int SW1  = (SW0 > OFW) ? SW0 : OFW;
  localparam int SW   = SW1 + 2;
  localparam int CMPW = (DW > sapd_pkg::YAW_CMP_WIDTH) ? DW : sapd_pkg::YAW_CMP_WIDTH;

  localparam logic signed [DW-1:0] YAW_HI_POS  = DW'(sapd_pkg::YAW_TQ_HI);
  localparam logic signed [DW-1:0] YAW_HI_NEG  = -DW'(sapd_pkg::YAW_TQ_HI);
  localparam logic signed [DW-1:0] YAW_MID_POS = DW'(sapd_pkg::YAW_TQ_MID);
  localparam logic signed [DW-1:0] YAW_LO_POS  = DW'(sapd_pkg::YAW_TQ_LO);

  // Floor a Q.24 sum to Q12.12 and clamp it to the signed output range.
  function automatic logic signed [DW-1:0] sat_q(input logic signed [SW-1:0] acc);
    logic signed [SW-1:0] sh;
    logic signed [DW-1:0] res;
    sh = acc >>> sapd_pkg::FRAC_BITS;
    if (sh[SW-1:DW-1] == {(SW-DW+1){sh[SW-1]}}) begin
      res = sh[DW-1:0];
    end else if (sh[SW-1]) begin
      res = {1'b1, {(DW-1){1'b0}}};
    end else begin
      res = {1'b0, {(DW-1){1'b1}}};
    end
    return res;
  endfunction

  // Configuration registers.
  logic [sapd_pkg::AXES*GW-1:0]          pos_gains;
  logic [sapd_pkg::AXES*GW-1:0]          vel_gains;
  logic [sapd_pkg::AXES*GW-1:0]          att_gains;
  logic [sapd_pkg::AXES*GW-1:0]          rate_gains;
  logic [sapd_pkg::OFFSET_WIDTH-1:0]     heave_offset;

  sapd_cfg_regs #(
    .GAIN_WIDTH (GW)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pos_gains    (pos_gains),
    .vel_gains    (vel_gains),
    .att_gains    (att_gains),
    .rate_gains   (rate_gains),
    .heave_offset (heave_offset)
  );

  assign pready = 1'b1;

  // Flow control between the input register and the result register.
  logic s1_valid;
  logic o_ready;
  logic in_take;
  logic o_load;

  assign o_ready  = !out_valid || out_ready;
  assign in_ready = !s1_valid || o_ready;
  assign in_take  = in_valid && in_ready;
  assign o_load   = s1_valid && o_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (o_load) begin
        s1_valid <= 1'b0;
      end
      if (o_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Stage 1: input register.
  logic signed [DW-1:0] ex;
  logic signed [DW-1:0] ey;
  logic signed [DW-1:0] ez;
  logic signed [DW-1:0] vx;
  logic signed [DW-1:0] vy;
  logic signed [DW-1:0] vz;
  logic signed [DW-1:0] ar;
  logic signed [DW-1:0] ap;
  logic signed [DW-1:0] ay;
  logic signed [DW-1:0] wr;
  logic signed [DW-1:0] wp;
  logic signed [DW-1:0] wy;

  always_ff @(posedge clk) begin
    if (in_take) begin
      ex <= pos_err_x;
      ey <= pos_err_y;
      ez <= pos_err_z;
      vx <= vel_err_x;
      vy <= vel_err_y;
      vz <= vel_err_z;
      ar <= att_err_roll;
      ap <= att_err_pitch;
      ay <= att_err_yaw;
      wr <= rate_roll;
      wp <= rate_pitch;
      wy <= rate_yaw;
    end
  end

  // Gain slices, one per axis.
  logic signed [GW-1:0] g_px;
  logic signed [GW-1:0] g_py;
  logic signed [GW-1:0] g_pz;
  logic signed [GW-1:0] g_vx;
  logic signed [GW-1:0] g_vy;
  logic signed [GW-1:0] g_vz;
  logic signed [GW-1:0] g_ar;
  logic signed [GW-1:0] g_ap;
  logic signed [GW-1:0] g_ay;
  logic signed [GW-1:0] g_wr;
  logic signed [GW-1:0] g_wp;
  logic signed [GW-1:0] g_wy;

  assign g_px = pos_gains[0 +: GW];
  assign g_py = pos_gains[GW +: GW];
  assign g_pz = pos_gains[2*GW +: GW];
  assign g_vx = vel_gains[0 +: GW];
  assign g_vy = vel_gains[GW +: GW];
  assign g_vz = vel_gains[2*GW +: GW];
  assign g_ar = att_gains[0 +: GW];
  assign g_ap = att_gains[GW +: GW];
  assign g_ay = att_gains[2*GW +: GW];
  assign g_wr = rate_gains[0 +: GW];
  assign g_wp = rate_gains[GW +: GW];
  assign g_wy = rate_gains[2*GW +: GW];

  // Magnitudes of sway error and yaw error; the most negative code maps to 2^(DW-1).
  logic [DW-1:0]    abs_ey;
  logic [DW-1:0]    abs_yaw;
  logic [CMPW-1:0]  yaw_cmp;
  logic [CFW-1:0]   couple_full;
  logic [CPW-1:0]   couple;
  logic [1:0]       band_next;
  logic             yaw_neg;

  assign abs_ey      = ey[DW-1] ? (~ey + 1'b1) : ey;
  assign abs_yaw     = ay[DW-1] ? (~ay + 1'b1) : ay;
  assign yaw_cmp     = CMPW'(abs_yaw);
  assign couple_full = CFW'(abs_ey) * CFW'(sapd_pkg::SWAY_COUPLE);
  assign couple      = couple_full[CFW-1:sapd_pkg::COUPLE_SHIFT];
  assign yaw_neg     = ay[DW-1];

  // Yaw band selection; the strictly greater compare keeps a threshold in the lower band.
  always_comb begin
    priority if (yaw_cmp > CMPW'(sapd_pkg::YAW_BAND_HI)) begin
      band_next = sapd_pkg::BAND_HI;
    end else if (yaw_cmp > CMPW'(sapd_pkg::YAW_BAND_MID)) begin
      band_next = sapd_pkg::BAND_MID;
    end else if (yaw_cmp > CMPW'(sapd_pkg::YAW_BAND_LO)) begin
      band_next = sapd_pkg::BAND_LO;
    end else begin
      band_next = sapd_pkg::BAND_NONE;
    end
  end

  // Products of each gain with its error or rate, exact in Q.24.
  logic signed [PW-1:0] p_px;
  logic signed [PW-1:0] p_py;
  logic signed [PW-1:0] p_pz;
  logic signed [PW-1:0] p_vx;
  logic signed [PW-1:0] p_vy;
  logic signed [PW-1:0] p_vz;
  logic signed [PW-1:0] p_ar;
  logic signed [PW-1:0] p_ap;
  logic signed [PW-1:0] p_ay;
  logic signed [PW-1:0] p_wr;
  logic signed [PW-1:0] p_wp;
  logic signed [PW-1:0] p_wy;

  assign p_px = g_px * ex;
  assign p_py = g_py * ey;
  assign p_pz = g_pz * ez;
  assign p_vx = g_vx * vx;
  assign p_vy = g_vy * vy;
  assign p_vz = g_vz * vz;
  assign p_ar = g_ar * ar;
  assign p_ap = g_ap * ap;
  assign p_ay = g_ay * ay;
  assign p_wr = g_wr * wr;
  assign p_wp = g_wp * wp;
  assign p_wy = g_wy * wy;

  // Axis sums in Q.24.
  logic signed [SW-1:0] sum_surge;
  logic signed [SW-1:0] sum_sway;
  logic signed [SW-1:0] sum_heave;
  logic signed [SW-1:0] sum_roll;
  logic signed [SW-1:0] sum_pitch;
  logic signed [SW-1:0] sum_yaw;
  logic signed [OFW-1:0] offset_q24;
  logic signed [DW-1:0]  yaw_mag;
  logic signed [DW-1:0]  yaw_fixed;
  logic                  banded;

  assign offset_q24 = $signed({heave_offset, {sapd_pkg::FRAC_BITS{1'b0}}});
  assign sum_surge  = SW'(p_px) + SW'(p_vx) - SW'($signed({1'b0, couple}));
  assign sum_sway   = SW'(p_py) + SW'(p_vy);
  assign sum_heave  = SW'(p_pz) + SW'(p_vz) + SW'(offset_q24);
  assign sum_roll   = SW'(p_ar) + SW'(p_wr);
  assign sum_pitch  = SW'(p_ap) + SW'(p_wp);
  assign sum_yaw    = SW'(p_ay) + SW'(p_wy);

  // Fixed yaw torque for the banded cases.
  always_comb begin
    unique case (band_next)
      sapd_pkg::BAND_HI:  yaw_mag = YAW_HI_POS;
      sapd_pkg::BAND_MID: yaw_mag = YAW_MID_POS;
      sapd_pkg::BAND_LO:  yaw_mag = YAW_LO_POS;
      default:            yaw_mag = '0;
    endcase
  end

  assign banded    = (band_next != sapd_pkg::BAND_NONE);
  assign yaw_fixed = yaw_neg ? -yaw_mag : yaw_mag;

  // Stage 2: result register.
  always_ff @(posedge clk) begin
    if (o_load) begin
      force_surge  <= banded ? '0 : sat_q(sum_surge);
      force_sway   <= banded ? '0 : sat_q(sum_sway);
      force_heave  <= sat_q(sum_heave);
      torque_roll  <= sat_q(sum_roll);
      torque_pitch <= sat_q(sum_pitch);
      torque_yaw   <= banded ? yaw_fixed : sat_q(sum_yaw);
    end
  end

  // A new request only lands in a full input stage when that stage is moving on.
  `SAPD_ASSERT_IMP(a_s1_no_overwrite, in_take && s1_valid, o_load)
  // A banded yaw request leaves zero surge and sway in the result.
  `SAPD_ASSERT_NXT(a_band_zero_xy, o_load && banded, force_surge == '0 && force_sway == '0)
  // The largest yaw band gives the full fixed torque with the sign of the error.
  `SAPD_ASSERT_NXT(a_yaw_hi_torque, o_load && band_next == sapd_pkg::BAND_HI,
                   torque_yaw == YAW_HI_POS || torque_yaw == YAW_HI_NEG)
  // The pipeline comes out of reset empty.
  `SAPD_ASSERT_IMP(a_reset_empty, $past(rst), !out_valid && !s1_valid)

endmodule

@@ rtl/sapd_cfg_regs.sv @@
module sapd_cfg_regs #(
  parameter int GAIN_WIDTH = sapd_pkg::GAIN_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [sapd_pkg::APB_ADDR_WIDTH-1:0]    paddr,
  input  logic [sapd_pkg::APB_DATA_WIDTH-1:0]    pwdata,
  output logic [sapd_pkg::APB_DATA_WIDTH-1:0]    prdata,
  output logic [sapd_pkg::AXES*GAIN_WIDTH-1:0]   pos_gains,
  output logic [sapd_pkg::AXES*GAIN_WIDTH-1:0]   vel_gains,
  output logic [sapd_pkg::AXES*GAIN_WIDTH-1:0]   att_gains,
  output logic [sapd_pkg::AXES*GAIN_WIDTH-1:0]   rate_gains,
  output logic [sapd_pkg::OFFSET_WIDTH-1:0]      heave_offset
);

  localparam int GW3 = sapd_pkg::AXES * GAIN_WIDTH;

  logic                                  wr_en;
  logic [sapd_pkg::REG_SEL_WIDTH-1:0]    reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[sapd_pkg::APB_ADDR_WIDTH-1:sapd_pkg::REG_SEL_LSB];

  // Register writes; addresses past the last register are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_gains    <= '0;
      vel_gains    <= '0;
      att_gains    <= '0;
      rate_gains   <= '0;
      heave_offset <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        sapd_pkg::REG_POS_GAINS:    pos_gains    <= pwdata[GW3-1:0];
        sapd_pkg::REG_VEL_GAINS:    vel_gains    <= pwdata[GW3-1:0];
        sapd_pkg::REG_ATT_GAINS:    att_gains    <= pwdata[GW3-1:0];
        sapd_pkg::REG_RATE_GAINS:   rate_gains   <= pwdata[GW3-1:0];
        sapd_pkg::REG_HEAVE_OFFSET: heave_offset <= pwdata[sapd_pkg::OFFSET_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    unique case (reg_sel)
      sapd_pkg::REG_POS_GAINS:    prdata = sapd_pkg::APB_DATA_WIDTH'(pos_gains);
      sapd_pkg::REG_VEL_GAINS:    prdata = sapd_pkg::APB_DATA_WIDTH'(vel_gains);
      sapd_pkg::REG_ATT_GAINS:    prdata = sapd_pkg::APB_DATA_WIDTH'(att_gains);
      sapd_pkg::REG_RATE_GAINS:   prdata = sapd_pkg::APB_DATA_WIDTH'(rate_gains);
      sapd_pkg::REG_HEAVE_OFFSET: prdata = sapd_pkg::APB_DATA_WIDTH'(heave_offset);
      default:                    prdata = '0;
    endcase
  end

endmodule
